// ----- src/lst_pkg.sv -----
`default_nettype none
package lst_pkg;

    localparam logic [4:0] KIND_END     = 5'd0;
    localparam logic [4:0] KIND_STRING  = 5'd1;
    localparam logic [4:0] KIND_INT     = 5'd2;
    localparam logic [4:0] KIND_KW_BASE = 5'd3;
    localparam logic [4:0] KIND_OP_BASE = 5'd14;

    localparam int          NUM_KW  = 11;
    localparam int          KW_MAXL = 13;
    localparam logic [62:0] VAL_MAX = {63{1'b1}};
    localparam logic [23:0] LINE_MAX = {24{1'b1}};

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [62:0] int_value;
        logic [7:0]  text_byte;
        logic [4:0]  text_pos;
        logic        last;
        logic [23:0] line_number;
        logic        truncated;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_ZERO  = 3'd1,
        PH_ZEROX = 3'd2,
        PH_HEX   = 3'd3,
        PH_DEC   = 3'd4,
        PH_OCT   = 3'd5,
        PH_TEXT  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RD   = 2'd1,
        ST_WR   = 2'd2,
        ST_TAIL = 2'd3
    } state_t;

    // Keyword text, right justified, first character in the high byte
    function automatic logic [KW_MAXL*8-1:0] kw_text(input int idx);
        logic [KW_MAXL*8-1:0] t;
        begin
            case (idx)
                0:       t = "SECTIONS";
                1:       t = "ENTRY";
                2:       t = "PHDRS";
                3:       t = "TARGET";
                4:       t = "ALIGN";
                5:       t = "BLOCK";
                6:       t = {"OUTPUT_", "FORMAT"};
                7:       t = "OUTPUT";
                8:       t = "FILEHDR";
                9:       t = "AT";
                10:      t = "FLAGS";
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    function automatic logic [3:0] kw_len(input int idx);
        logic [3:0] l;
        begin
            case (idx)
                0:       l = 4'd8;
                1:       l = 4'd5;
                2:       l = 4'd5;
                3:       l = 4'd6;
                4:       l = 4'd5;
                5:       l = 4'd5;
                6:       l = 4'd13;
                7:       l = 4'd6;
                8:       l = 4'd7;
                9:       l = 4'd2;
                10:      l = 4'd5;
                default: l = 4'd0;
            endcase
            return l;
        end
    endfunction

    // Character of keyword idx at position pos, zero beyond its end
    function automatic logic [7:0] kw_char(input int idx, input int pos);
        logic [KW_MAXL*8-1:0] t;
        int l;
        begin
            t = kw_text(idx);
            l = int'(kw_len(idx));
            if (pos >= l || pos < 0)
                return 8'd0;
            return t[(l-1-pos)*8 +: 8];
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/lst_word_mem.sv -----
`default_nettype none
module lst_word_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- src/lst_number.sv -----
`default_nettype none
module lst_number (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        start,
    input  wire logic [7:0]  c,
    output logic             is_num,
    output logic [62:0]      value
);

    lst_pkg::phase_t phase_reg, phase_next, ph;
    logic [62:0] acc_reg, acc_next, acc;
    logic        stop_reg, stop_next, stp;
    logic [7:0]  sc_reg, sc_next, sc;
    logic [4:0]  d;
    logic [4:0]  radix;
    logic [66:0] prod;
    logic [66:0] sum;
    logic [62:0] mac;
    logic        is_dig;

    // Digit value, 16 when not a hex digit
    always_comb
    begin
        d = 5'd16;
        if (c >= "0" && c <= "9")
            d = 5'(c - "0");
        else if (c >= "a" && c <= "f")
            d = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            d = 5'(c - "A" + 8'd10);
        is_dig = (c >= "0" && c <= "9");
    end

    // Current view: a new word starts from cleared state
    always_comb
    begin
        ph  = start ? lst_pkg::PH_FIRST : phase_reg;
        acc = start ? 63'd0 : acc_reg;
        stp = start ? 1'b0 : stop_reg;
        sc  = start ? 8'd0 : sc_reg;
    end

    // Multiply by radix with shifts, add digit, saturate
    always_comb
    begin
        case (ph)
            lst_pkg::PH_HEX: radix = 5'd16;
            lst_pkg::PH_OCT: radix = 5'd8;
            default:         radix = 5'd10;
        endcase
        case (ph)
            lst_pkg::PH_HEX: prod = {acc, 4'b0};
            lst_pkg::PH_OCT: prod = {1'b0, acc, 3'b0};
            default:         prod = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0};
        endcase
        sum = prod + 67'(d);
        mac = (sum > 67'(lst_pkg::VAL_MAX)) ? lst_pkg::VAL_MAX : sum[62:0];
    end

    // Advance the radix state machine one byte
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        stop_next  = stop_reg;
        sc_next    = sc_reg;
        if (en)
        begin
            phase_next = ph;
            acc_next   = acc;
            stop_next  = stp;
            sc_next    = sc;
            if (!stp)
            begin
                case (ph)
                    lst_pkg::PH_FIRST:
                    begin
                        if (is_dig)
                        begin
                            phase_next = (c == "0") ? lst_pkg::PH_ZERO : lst_pkg::PH_DEC;
                            acc_next   = 63'(d);
                        end
                        else
                            phase_next = lst_pkg::PH_TEXT;
                    end
                    lst_pkg::PH_ZERO:
                    begin
                        if (c == "x" || c == "X")
                        begin
                            phase_next = lst_pkg::PH_ZEROX;
                            sc_next    = c;
                        end
                        else if (d < 5'd8)
                        begin
                            phase_next = lst_pkg::PH_OCT;
                            acc_next   = 63'(d);
                        end
                        else
                        begin
                            stop_next = 1'b1;
                            sc_next   = c;
                        end
                    end
                    lst_pkg::PH_ZEROX:
                    begin
                        if (d < 5'd16)
                        begin
                            phase_next = lst_pkg::PH_HEX;
                            acc_next   = 63'(d);
                        end
                        else
                            stop_next = 1'b1;
                    end
                    lst_pkg::PH_HEX, lst_pkg::PH_DEC, lst_pkg::PH_OCT:
                    begin
                        if (d < radix)
                            acc_next = mac;
                        else
                        begin
                            stop_next = 1'b1;
                            sc_next   = c;
                        end
                    end
                    default:
                    begin
                        phase_next = ph;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lst_pkg::PH_FIRST;
            acc_reg   <= '0;
            stop_reg  <= 1'b0;
            sc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            stop_reg  <= stop_next;
            sc_reg    <= sc_next;
        end
    end

    // Scale by K or M suffix, saturating
    always_comb
    begin
        is_num = (phase_reg >= lst_pkg::PH_ZERO) && (phase_reg <= lst_pkg::PH_OCT);
        value  = acc_reg;
        if (stop_reg && sc_reg == "K")
            value = (acc_reg[62:53] != '0) ? lst_pkg::VAL_MAX : {acc_reg[52:0], 10'b0};
        else if (stop_reg && sc_reg == "M")
            value = (acc_reg[62:43] != '0) ? lst_pkg::VAL_MAX : {acc_reg[42:0], 20'b0};
    end

endmodule
`default_nettype wire

// ----- src/linker_script_tokenizer_unit.sv -----
`default_nettype none
// Linker-script tokenizer: takes one script byte per transaction and emits the
// tokens it completes. Word bytes are written into a MAX_WORD-byte buffer RAM
// while integer parsing and keyword matching run alongside. A byte that yields
// at most one token is taken whenever the output register is free; a word
// closed by an operator or end of input holds input off while that second
// token is loaded. A string token is read back from the buffer RAM one byte
// at a time (read, then load the output), and input is held off until all of
// its bytes and any following operator or end token are loaded. Stalls on the
// result side add to all of these.
module linker_script_tokenizer_unit #(
    parameter int MAX_WORD = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lst_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lst_pkg::out_item_t     out_data
);

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int IDX_W = $clog2(MAX_WORD);

    lst_pkg::state_t    state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    lst_pkg::out_item_t out_reg, out_next;
    logic [23:0]        line_reg, line_next;
    logic [23:0]        tok_line_reg, tok_line_next;
    logic               in_word_reg, in_word_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [lst_pkg::NUM_KW-1:0] kwm_reg, kwm_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               tail_reg, tail_next;
    logic [4:0]         tail_kind_reg, tail_kind_next;

    logic               accept, slot_free;
    logic               is_blank, is_nl, is_op, is_sep, is_word_byte;
    logic [4:0]         op_kind;
    logic [4:0]         kw_kind;
    logic               kw_hit;
    logic               start;
    logic [LEN_W-1:0]   pos;
    logic               wr_en, rd_en;
    logic [7:0]         rd_data;
    logic               num_is;
    logic [62:0]        num_val;
    lst_pkg::out_item_t word_tok, tail_tok, str_tok;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == lst_pkg::ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Classify the incoming byte
    always_comb
    begin
        is_blank = (in_data.char_byte == " ") || (in_data.char_byte == 8'h09);
        is_nl    = !in_data.end_of_input && (in_data.char_byte == 8'h0A);
        is_op    = 1'b1;
        case (in_data.char_byte)
            "{":      op_kind = lst_pkg::KIND_OP_BASE;
            "}":      op_kind = lst_pkg::KIND_OP_BASE + 5'd1;
            "(":      op_kind = lst_pkg::KIND_OP_BASE + 5'd2;
            ")":      op_kind = lst_pkg::KIND_OP_BASE + 5'd3;
            "=":      op_kind = lst_pkg::KIND_OP_BASE + 5'd4;
            ";":      op_kind = lst_pkg::KIND_OP_BASE + 5'd5;
            ":":      op_kind = lst_pkg::KIND_OP_BASE + 5'd6;
            "+":      op_kind = lst_pkg::KIND_OP_BASE + 5'd7;
            "-":      op_kind = lst_pkg::KIND_OP_BASE + 5'd8;
            default:
            begin
                op_kind = lst_pkg::KIND_END;
                is_op   = 1'b0;
            end
        endcase
        if (in_data.end_of_input)
            is_op = 1'b0;
        is_sep       = in_data.end_of_input || is_blank || is_nl || is_op;
        is_word_byte = !is_sep;
    end

    // Word byte bookkeeping
    assign start = !in_word_reg;
    assign pos   = start ? '0 : len_reg;
    assign wr_en = accept && is_word_byte && (pos < LEN_W'(MAX_WORD));

    // Narrow keyword candidates by position
    always_comb
    begin
        for (int i = 0; i < lst_pkg::NUM_KW; i++)
            kwm_next[i] = kwm_reg[i];
        if (accept && is_word_byte)
        begin
            for (int i = 0; i < lst_pkg::NUM_KW; i++)
                kwm_next[i] = (start || kwm_reg[i])
                    && (int'(pos) < int'(lst_pkg::kw_len(i)))
                    && (in_data.char_byte == lst_pkg::kw_char(i, int'(pos)));
        end
    end

    // Pick the matching keyword of the right length
    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = lst_pkg::KIND_END;
        for (int i = lst_pkg::NUM_KW - 1; i >= 0; i--)
        begin
            if (kwm_reg[i] && (len_reg == LEN_W'(lst_pkg::kw_len(i))))
            begin
                kw_hit  = 1'b1;
                kw_kind = lst_pkg::KIND_KW_BASE + 5'(i);
            end
        end
        if (ovf_reg)
            kw_hit = 1'b0;
    end

    lst_word_mem #(
        .DEPTH (MAX_WORD),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(pos)),
        .wr_data (in_data.char_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    lst_number u_num (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (accept && is_word_byte),
        .start  (start),
        .c      (in_data.char_byte),
        .is_num (num_is),
        .value  (num_val)
    );

    // Assemble candidate result items
    always_comb
    begin
        word_tok             = '0;
        word_tok.last        = 1'b1;
        word_tok.line_number = line_reg;
        if (num_is)
        begin
            word_tok.kind      = lst_pkg::KIND_INT;
            word_tok.int_value = num_val;
            word_tok.truncated = ovf_reg;
        end
        else
            word_tok.kind = kw_kind;

        tail_tok             = '0;
        tail_tok.last        = 1'b1;
        tail_tok.kind        = tail_kind_reg;
        tail_tok.line_number = tok_line_reg;

        str_tok              = '0;
        str_tok.kind         = lst_pkg::KIND_STRING;
        str_tok.text_byte    = rd_data;
        str_tok.text_pos     = 5'(rd_idx_reg);
        str_tok.last         = (LEN_W'(rd_idx_reg) + LEN_W'(1)) == len_reg;
        str_tok.line_number  = tok_line_reg;
        str_tok.truncated    = ovf_reg;
    end

    // Next state and output register load
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        line_next      = line_reg;
        tok_line_next  = tok_line_reg;
        in_word_next   = in_word_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        rd_idx_next    = rd_idx_reg;
        tail_next      = tail_reg;
        tail_kind_next = tail_kind_reg;
        rd_en          = 1'b0;

        case (state_reg)
            lst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_word_byte)
                    begin
                        in_word_next = 1'b1;
                        if (pos < LEN_W'(MAX_WORD))
                        begin
                            len_next = pos + LEN_W'(1);
                            ovf_next = start ? 1'b0 : ovf_reg;
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        tok_line_next  = line_reg;
                        tail_next      = in_data.end_of_input || is_op;
                        tail_kind_next = in_data.end_of_input ? lst_pkg::KIND_END : op_kind;
                        if (is_nl && line_reg != lst_pkg::LINE_MAX)
                            line_next = line_reg + 24'd1;
                        in_word_next = 1'b0;
                        if (in_word_reg && !num_is && !kw_hit)
                        begin
                            // Drain the string from the buffer
                            rd_idx_next = '0;
                            state_next  = lst_pkg::ST_RD;
                        end
                        else if (in_word_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = word_tok;
                            if (in_data.end_of_input || is_op)
                                state_next = lst_pkg::ST_TAIL;
                        end
                        else if (in_data.end_of_input || is_op)
                        begin
                            out_valid_next       = 1'b1;
                            out_next             = '0;
                            out_next.last        = 1'b1;
                            out_next.line_number = line_reg;
                            out_next.kind = in_data.end_of_input ? lst_pkg::KIND_END : op_kind;
                        end
                    end
                end
            end
            lst_pkg::ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = lst_pkg::ST_WR;
            end
            lst_pkg::ST_WR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = str_tok;
                    if (str_tok.last)
                        state_next = tail_reg ? lst_pkg::ST_TAIL : lst_pkg::ST_IDLE;
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = lst_pkg::ST_RD;
                    end
                end
            end
            lst_pkg::ST_TAIL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = tail_tok;
                    state_next     = lst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lst_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lst_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            line_reg      <= '0;
            in_word_reg   <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            kwm_reg       <= '0;
            rd_idx_reg    <= '0;
            tail_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            line_reg      <= line_next;
            in_word_reg   <= in_word_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            kwm_reg       <= kwm_next;
            rd_idx_reg    <= rd_idx_next;
            tail_reg      <= tail_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        tok_line_reg  <= tok_line_next;
        tail_kind_reg <= tail_kind_next;
    end

`ifndef SYNTH
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != lst_pkg::ST_IDLE |-> !in_ready)
        else $error("input taken while draining a word");

    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lst_pkg::ST_RD |-> (LEN_W'(rd_idx_reg) < len_reg))
        else $error("string drain index past word length");

    a_read_before_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lst_pkg::ST_WR |-> $past(state_reg) == lst_pkg::ST_RD
            || $past(state_reg) == lst_pkg::ST_WR)
        else $error("string byte loaded without a buffer read");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");
`endif

endmodule
`default_nettype wire

// ----- test/lst_token_checker.sv -----
`timescale 1ns / 1ps
module lst_token_checker
    import lst_pkg::*;
#(
    parameter int MAX_WORD = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        tokens_pending
);

    localparam logic [7:0] OP_CHARS [9] = '{"{", "}", "(", ")", "=", ";", ":", "+", "-"};

    // tokenizer state mirror
    logic [23:0] lines_seen;
    logic [7:0]  word_bytes [MAX_WORD];
    int          word_len;
    bit          word_open;
    logic [62:0] number_acc;
    phase_t      num_phase;
    bit          num_halted;
    logic [7:0]  halt_char;
    bit          word_cut;

    out_item_t   expected_tokens [$];

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic logic [62:0] scale_sat(logic [62:0] a, int radix, int d);
        logic [63:0] lim;
        lim = (64'(VAL_MAX) - 64'(d)) / 64'(radix);
        if (64'(a) > lim) return VAL_MAX;
        return 63'(64'(a) * 64'(radix) + 64'(d));
    endfunction

    task automatic push_token(logic [4:0] k, logic [62:0] v, logic [7:0] b,
                              logic [4:0] p, logic l, logic t);
        out_item_t r;
        r.kind = k;
        r.int_value = v;
        r.text_byte = b;
        r.text_pos = p;
        r.last = l;
        r.line_number = lines_seen;
        r.truncated = t;
        expected_tokens.push_back(r);
    endtask

    task automatic track_number(logic [7:0] c);
        int d;
        int radix;
        d = hex_digit(c);
        radix = 0;
        if (num_halted) return;
        case (num_phase)
            PH_FIRST:
            begin
                if (c >= "0" && c <= "9")
                begin
                    num_phase = (c == "0") ? PH_ZERO : PH_DEC;
                    number_acc = 63'(d);
                end
                else
                    num_phase = PH_TEXT;
            end
            PH_ZERO:
            begin
                if (c == "x" || c == "X")
                begin
                    num_phase = PH_ZEROX;
                    halt_char = c;
                end
                else if (d < 8)
                begin
                    num_phase = PH_OCT;
                    number_acc = 63'(d);
                end
                else
                begin
                    num_halted = 1;
                    halt_char = c;
                end
            end
            PH_ZEROX:
            begin
                if (d < 16)
                begin
                    num_phase = PH_HEX;
                    number_acc = 63'(d);
                end
                else
                    num_halted = 1;
            end
            PH_HEX: radix = 16;
            PH_DEC: radix = 10;
            PH_OCT: radix = 8;
            default: ;
        endcase
        if (radix != 0)
        begin
            if (d < radix)
                number_acc = scale_sat(number_acc, radix, d);
            else
            begin
                num_halted = 1;
                halt_char = c;
            end
        end
    endtask

    task automatic close_word();
        logic [62:0] v;
        logic [63:0] f;
        bit          hit;
        if (!word_open) return;
        word_open = 0;
        if (num_phase >= PH_ZERO && num_phase <= PH_OCT)
        begin
            f = 1;
            if (num_halted && halt_char == "K") f = 1024;
            if (num_halted && halt_char == "M") f = 1024 * 1024;
            v = (64'(number_acc) > 64'(VAL_MAX) / f) ? VAL_MAX : 63'(64'(number_acc) * f);
            push_token(KIND_INT, v, 0, 0, 1, word_cut);
            return;
        end
        if (!word_cut)
        begin
            for (int i = 0; i < NUM_KW; i++)
            begin
                hit = (int'(kw_len(i)) == word_len);
                for (int j = 0; j < word_len && hit; j++)
                    if (kw_char(i, j) != word_bytes[j]) hit = 0;
                if (hit)
                begin
                    push_token(KIND_KW_BASE + 5'(i), 0, 0, 0, 1, 0);
                    return;
                end
            end
        end
        for (int i = 0; i < word_len; i++)
            push_token(KIND_STRING, 0, word_bytes[i], 5'(i), (i + 1 == word_len), word_cut);
    endtask

    task automatic predict_tokens(in_item_t it);
        logic [7:0] c;
        c = it.char_byte;
        if (it.end_of_input)
        begin
            close_word();
            push_token(KIND_END, 0, 0, 0, 1, 0);
            return;
        end
        if (c == " " || c == "\t")
        begin
            close_word();
            return;
        end
        if (c == "\n")
        begin
            close_word();
            if (lines_seen != LINE_MAX) lines_seen++;
            return;
        end
        for (int i = 0; i < 9; i++)
            if (c == OP_CHARS[i])
            begin
                close_word();
                push_token(KIND_OP_BASE + 5'(i), 0, 0, 0, 1, 0);
                return;
            end
        if (!word_open)
        begin
            word_open = 1;
            word_len = 0;
            word_cut = 0;
            num_phase = PH_FIRST;
            number_acc = 0;
            num_halted = 0;
            halt_char = 0;
        end
        if (word_len < MAX_WORD) word_bytes[word_len++] = c;
        else word_cut = 1;
        track_number(c);
    endtask

    // predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_seen = 0;
            word_len = 0;
            word_open = 0;
            number_acc = 0;
            num_phase = PH_FIRST;
            num_halted = 0;
            halt_char = 0;
            word_cut = 0;
            fail_count <= 0;
            expected_tokens.delete();
            tokens_pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_tokens(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token, expected none, got %p", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else if (expected_tokens[0] !== out_data)
                begin
                    $display("%0t: token mismatch, expected %p, got %p",
                             $time, expected_tokens[0], out_data);
                    fail_count <= fail_count + 1;
                    void'(expected_tokens.pop_front());
                end
                else
                    void'(expected_tokens.pop_front());
            end
            tokens_pending <= expected_tokens.size();
        end
    end

endmodule

// ----- test/tb_linker_script_tokenizer_unit.sv -----
`timescale 1ns / 1ps
module tb_linker_script_tokenizer_unit;
    import lst_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        tokens_pending;
    int        hold_cycles;

    linker_script_tokenizer_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    lst_token_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .tokens_pending(tokens_pending)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    // hold the run to a hard limit
    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // drive one transaction and wait for acceptance, with random gaps
    task automatic send_char(logic [7:0] c, logic eoi);
        in_valid <= 1;
        in_data.char_byte <= c;
        in_data.end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if ($urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 0);
    endtask

    // send the text of one keyword from the package table
    task automatic send_kw(int idx);
        for (int j = 0; j < int'(kw_len(idx)); j++) send_char(kw_char(idx, j), 0);
    endtask

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range("0", "9"));
            3:       return "x";
            4:       return "K";
            5:       return "M";
            6:       return 8'($urandom_range("a", "f"));
            7:       return 8'($urandom_range("A", "Z"));
            8:       return 8'($urandom_range(0, 255));
            default: return "_";
        endcase
    endfunction

    task automatic send_random_word();
        string seps = " \t\n{}()=;:+-";
        int    n;
        case ($urandom_range(0, 5))
            0: send_kw($urandom_range(0, NUM_KW - 1));
            1: send_text($urandom_range(0, 1) ? "0x" : "0");
            default: ;
        endcase
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) send_char(rand_word_char(), 0);
        send_char(seps[$urandom_range(0, seps.len() - 1)], 0);
    endtask

    // receiver stall pattern with one long hold-off
    initial
    begin
        out_ready = 0;
        hold_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles == 300)
            begin
                out_ready <= 0;
                repeat (200) @(posedge clk);
            end
            hold_cycles++;
            out_ready <= (hold_cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: operators, keywords, radixes, suffixes, saturation, long words
        send_text("{}()=;:+-\n");
        for (int i = 0; i < NUM_KW; i++)
        begin
            send_kw(i);
            send_char((i % 2 != 0) ? "\t" : " ", 0);
        end
        send_char("\n", 0);
        send_text("0x1fK 0x 0XM 017 08 4K 3M 0 99999999999999999999M 0xFFFFFFFFFFFFFFFFF ");
        send_char(8'h00, 0);
        send_char(8'hFF, 0);
        send_text("abc;");
        send_text("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghij 1234567890123456789012345678901234(");
        send_char(8'h41, 1);
        send_char(8'hFF, 1);

        // pause until all tokens drain
        in_valid <= 0;
        while (tokens_pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        // random scripts in bursts
        for (int i = 0; i < 12; i++)
        begin
            send_random_word();
            if ($urandom_range(0, 7) == 0) send_char(8'($urandom_range(0, 255)), 1);
        end
        send_char(0, 1);
        in_valid <= 0;

        while (tokens_pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
